### rtl/bpts_pkg.sv
// Package with item types, pattern codes and register indexes of the buzzer tone sequencer
`timescale 1ns / 1ps

package bpts_pkg;

    typedef enum logic [2:0] {
        PAT_OFF    = 3'd0,
        PAT_DOUBLE = 3'd1,
        PAT_SINGLE = 3'd2,
        PAT_BEEP   = 3'd3,
        PAT_ALARM  = 3'd4
    } pattern_t;

    typedef enum logic [2:0] {
        REG_TONE_A_PERIOD = 3'd0,
        REG_TONE_B_PERIOD = 3'd1,
        REG_ALARM_PERIOD  = 3'd2,
        REG_SHORT_MS      = 3'd3,
        REG_LONG_MS       = 3'd4,
        REG_TICKS_PER_MS  = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        STEP_START = 2'd0,
        STEP_FIRST = 2'd1,
        STEP_GAP   = 2'd2,
        STEP_LAST  = 2'd3
    } step_t;

    localparam logic [15:0] TONE_A_PERIOD_RST = 16'd333;
    localparam logic [15:0] TONE_B_PERIOD_RST = 16'd500;
    localparam logic [15:0] ALARM_PERIOD_RST  = 16'd4000;
    localparam logic [15:0] SHORT_MS_RST      = 16'd100;
    localparam logic [15:0] LONG_MS_RST       = 16'd200;
    localparam logic [15:0] TICKS_PER_MS_RST  = 16'd1000;

    typedef struct packed {
        logic       cmd;
        logic [2:0] pattern;
    } in_item_t;

    typedef struct packed {
        logic       tone_out;
        logic [2:0] active_pattern;
        logic       busy_res;
    } out_item_t;

endpackage

### rtl/buzzer_pattern_tone_sequencer.sv
// Top level of the buzzer pattern tone sequencer
`timescale 1ns / 1ps

// Channel   Signals                                  Direction
// in        in_valid, in_ready, in_data              item in, one base tick each
// out       out_valid, out_ready, out_data           item out, one per tick
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// One item per cycle unless the skid is full; each result is registered before out_data.
// The tick updates the pattern, timer and wave registers in the cycle it is taken.
// A two-entry output buffer (output register plus skid) holds results under stall;
// in_ready drops only while the skid entry is full.
// Reset clears all control state and loads the register defaults; cfg_ready is always high.

module buzzer_pattern_tone_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bpts_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bpts_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    logic [15:0] tone_a_period_reg;
    logic [15:0] tone_b_period_reg;
    logic [15:0] alarm_period_reg;
    logic [15:0] short_ms_reg;
    logic [15:0] long_ms_reg;
    logic [15:0] ticks_per_ms_reg;

    bpts_pkg::pattern_t cur_pattern_reg, cur_pattern_next;
    bpts_pkg::step_t    step_reg, step_next;
    logic [15:0]        ms_remaining_reg, ms_remaining_next;
    logic [15:0]        sub_ms_reg, sub_ms_next;
    logic [15:0]        wave_reg, wave_next;
    logic [15:0]        period_reg, period_next;

    logic                out_valid_reg, out_valid_next;
    bpts_pkg::out_item_t out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    bpts_pkg::out_item_t skid_data_reg, skid_data_next;

    bpts_pkg::out_item_t result;
    bpts_pkg::pattern_t  req;
    logic                accept;
    logic                pop;
    logic                expired;
    logic                tone;
    logic [16:0]         sub_inc;
    logic [16:0]         wave_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_a_period_reg <= bpts_pkg::TONE_A_PERIOD_RST;
            tone_b_period_reg <= bpts_pkg::TONE_B_PERIOD_RST;
            alarm_period_reg  <= bpts_pkg::ALARM_PERIOD_RST;
            short_ms_reg      <= bpts_pkg::SHORT_MS_RST;
            long_ms_reg       <= bpts_pkg::LONG_MS_RST;
            ticks_per_ms_reg  <= bpts_pkg::TICKS_PER_MS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bpts_pkg::REG_TONE_A_PERIOD: tone_a_period_reg <= cfg_data;
                bpts_pkg::REG_TONE_B_PERIOD: tone_b_period_reg <= cfg_data;
                bpts_pkg::REG_ALARM_PERIOD:  alarm_period_reg  <= cfg_data;
                bpts_pkg::REG_SHORT_MS:      short_ms_reg      <= cfg_data;
                bpts_pkg::REG_LONG_MS:       long_ms_reg       <= cfg_data;
                bpts_pkg::REG_TICKS_PER_MS:  ticks_per_ms_reg  <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // one tick of the step machine, timer and square wave
    always_comb
    begin
        cur_pattern_next  = cur_pattern_reg;
        step_next         = step_reg;
        ms_remaining_next = ms_remaining_reg;
        sub_ms_next       = sub_ms_reg;
        wave_next         = wave_reg;
        period_next       = period_reg;
        req               = bpts_pkg::PAT_OFF;
        tone              = 1'b0;
        wave_inc          = '0;

        if (in_data.cmd)
        begin
            if (in_data.pattern <= bpts_pkg::PAT_ALARM)
            begin
                req = bpts_pkg::pattern_t'(in_data.pattern);
            end
            if (req != cur_pattern_reg)
            begin
                cur_pattern_next  = req;
                step_next         = bpts_pkg::STEP_START;
                period_next       = '0;
                ms_remaining_next = '0;
                sub_ms_next       = '0;
                wave_next         = '0;
            end
        end

        expired = (ms_remaining_next == '0);

        unique case (cur_pattern_next)
            bpts_pkg::PAT_DOUBLE:
            begin
                priority if (step_next == bpts_pkg::STEP_START)
                begin
                    period_next       = tone_a_period_reg;
                    ms_remaining_next = short_ms_reg;
                    sub_ms_next       = '0;
                    step_next         = bpts_pkg::STEP_FIRST;
                end
                else if (expired && step_next == bpts_pkg::STEP_FIRST)
                begin
                    period_next       = '0;
                    ms_remaining_next = short_ms_reg;
                    sub_ms_next       = '0;
                    step_next         = bpts_pkg::STEP_GAP;
                end
                else if (expired && step_next == bpts_pkg::STEP_GAP)
                begin
                    period_next       = tone_a_period_reg;
                    ms_remaining_next = short_ms_reg;
                    sub_ms_next       = '0;
                    step_next         = bpts_pkg::STEP_LAST;
                end
                else if (expired)
                begin
                    period_next       = '0;
                    cur_pattern_next  = bpts_pkg::PAT_OFF;
                    step_next         = bpts_pkg::STEP_START;
                    ms_remaining_next = '0;
                    sub_ms_next       = '0;
                end
                else
                begin
                end
            end
            bpts_pkg::PAT_SINGLE, bpts_pkg::PAT_BEEP:
            begin
                priority if (step_next == bpts_pkg::STEP_START)
                begin
                    if (cur_pattern_next == bpts_pkg::PAT_BEEP)
                    begin
                        period_next       = tone_b_period_reg;
                        ms_remaining_next = long_ms_reg;
                    end
                    else
                    begin
                        period_next       = tone_a_period_reg;
                        ms_remaining_next = short_ms_reg;
                    end
                    sub_ms_next = '0;
                    step_next   = bpts_pkg::STEP_FIRST;
                end
                else if (expired)
                begin
                    period_next       = '0;
                    cur_pattern_next  = bpts_pkg::PAT_OFF;
                    step_next         = bpts_pkg::STEP_START;
                    ms_remaining_next = '0;
                    sub_ms_next       = '0;
                end
                else
                begin
                end
            end
            bpts_pkg::PAT_ALARM:
            begin
                period_next = alarm_period_reg;
            end
            default:
            begin
                period_next = '0;
            end
        endcase

        // advance the millisecond timer
        sub_inc = {1'b0, sub_ms_next} + 17'd1;
        if (ms_remaining_next != '0)
        begin
            if (sub_inc >= {1'b0, ticks_per_ms_reg})
            begin
                sub_ms_next       = '0;
                ms_remaining_next = ms_remaining_next - 16'd1;
            end
            else
            begin
                sub_ms_next = sub_inc[15:0];
            end
        end

        // advance the square wave
        if (period_next != period_reg)
        begin
            wave_next = '0;
        end
        if (period_next == '0)
        begin
            wave_next = '0;
        end
        else
        begin
            if (wave_next >= period_next)
            begin
                wave_next = '0;
            end
            tone     = (wave_next < (period_next >> 1));
            wave_inc = {1'b0, wave_next} + 17'd1;
            wave_next = (wave_inc >= {1'b0, period_next}) ? '0 : wave_inc[15:0];
        end

        result.tone_out       = tone;
        result.active_pattern = cur_pattern_next;
        result.busy_res       = (cur_pattern_next != bpts_pkg::PAT_OFF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pattern_reg  <= bpts_pkg::PAT_OFF;
            step_reg         <= bpts_pkg::STEP_START;
            ms_remaining_reg <= '0;
            sub_ms_reg       <= '0;
            wave_reg         <= '0;
            period_reg       <= '0;
        end
        else if (accept)
        begin
            cur_pattern_reg  <= cur_pattern_next;
            step_reg         <= step_next;
            ms_remaining_reg <= ms_remaining_next;
            sub_ms_reg       <= sub_ms_next;
            wave_reg         <= wave_next;
            period_reg       <= period_next;
        end
    end

    // output register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end
        else if (out_valid_reg)
        begin
            if (accept)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
        else
        begin
            out_valid_next = accept;
            out_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### rtl/bpts_checker.sv
// Port checker for the buzzer pattern tone sequencer, bound to the top level
`timescale 1ns / 1ps

module bpts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input bpts_pkg::out_item_t out_data
);

    a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.busy_res == (out_data.active_pattern != bpts_pkg::PAT_OFF)))
        else $error("busy_res disagrees with active_pattern");

    a_pattern_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.active_pattern <= bpts_pkg::PAT_ALARM))
        else $error("active_pattern out of range");

    a_tone_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.tone_out) |-> out_data.busy_res)
        else $error("tone high while no pattern runs");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled output item changed");

    a_ready_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready)
        else $error("input stalled after output drained");

endmodule

bind buzzer_pattern_tone_sequencer bpts_checker u_bpts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### test/tb.sv
// Testbench for the buzzer pattern tone sequencer: directed table plus random ticks vs predictor
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 15;
    localparam int PHASE_TICKS  = 60;
    localparam int NUM_DIR      = 41;

    typedef enum logic {
        ROW_TICK = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [2:0]          idx;
        logic [15:0]         val;
        bpts_pkg::in_item_t  tick;
        logic                lit;
        bpts_pkg::out_item_t want;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, 3'd7},
          1'b1, '{1'b0, bpts_pkg::PAT_OFF, 1'b0}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_ALARM},
          1'b1, '{1'b1, bpts_pkg::PAT_ALARM, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, bpts_pkg::PAT_OFF},
          1'b1, '{1'b1, bpts_pkg::PAT_ALARM, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, 3'd7},
          1'b1, '{1'b0, bpts_pkg::PAT_OFF, 1'b0}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, 3'd5},
          1'b1, '{1'b0, bpts_pkg::PAT_OFF, 1'b0}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, 3'd6},
          1'b1, '{1'b0, bpts_pkg::PAT_OFF, 1'b0}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_SINGLE},
          1'b1, '{1'b1, bpts_pkg::PAT_SINGLE, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_SINGLE},
          1'b1, '{1'b1, bpts_pkg::PAT_SINGLE, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_DOUBLE},
          1'b1, '{1'b1, bpts_pkg::PAT_DOUBLE, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_BEEP},
          1'b1, '{1'b1, bpts_pkg::PAT_BEEP, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_OFF},
          1'b1, '{1'b0, bpts_pkg::PAT_OFF, 1'b0}},
        '{ROW_CFG,  bpts_pkg::REG_TICKS_PER_MS,  16'd1, '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_SHORT_MS,      16'd1, '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_LONG_MS,       16'd2, '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_TONE_A_PERIOD, 16'd4, '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_TONE_B_PERIOD, 16'd2, '0, 1'b0, '0},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_DOUBLE}, 1'b0, '0},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, 3'd5},       1'b0, '0},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, 3'd2},       1'b0, '0},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, 3'd0},       1'b0, '0},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, 3'd7},       1'b0, '0},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, 3'd1},       1'b0, '0},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, 3'd4},       1'b0, '0},
        '{ROW_CFG,  3'd6, 16'hFFFF, '0, 1'b0, '0},
        '{ROW_CFG,  3'd7, 16'hFFFF, '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_TONE_A_PERIOD, 16'hFFFF, '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_TONE_B_PERIOD, 16'd0,    '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_ALARM_PERIOD,  16'd1,    '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_SHORT_MS,      16'd0,    '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_LONG_MS,       16'hFFFF, '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_TICKS_PER_MS,  16'd0,    '0, 1'b0, '0},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_ALARM},
          1'b1, '{1'b0, bpts_pkg::PAT_ALARM, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_BEEP},
          1'b1, '{1'b0, bpts_pkg::PAT_BEEP, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_SINGLE},
          1'b1, '{1'b1, bpts_pkg::PAT_SINGLE, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, bpts_pkg::PAT_OFF},
          1'b1, '{1'b0, bpts_pkg::PAT_OFF, 1'b0}},
        '{ROW_CFG,  bpts_pkg::REG_TICKS_PER_MS,  16'hFFFF, '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_SHORT_MS,      16'hFFFF, '0, 1'b0, '0},
        '{ROW_CFG,  bpts_pkg::REG_ALARM_PERIOD,  16'hFFFF, '0, 1'b0, '0},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_DOUBLE},
          1'b1, '{1'b1, bpts_pkg::PAT_DOUBLE, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b1, bpts_pkg::PAT_ALARM},
          1'b1, '{1'b1, bpts_pkg::PAT_ALARM, 1'b1}},
        '{ROW_TICK, 3'd0, 16'd0, '{1'b0, 3'd3},       1'b0, '0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    bpts_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    bpts_pkg::out_item_t out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [15:0]         cfg_data = '0;

    logic [15:0] regs [6] = '{bpts_pkg::TONE_A_PERIOD_RST, bpts_pkg::TONE_B_PERIOD_RST,
                              bpts_pkg::ALARM_PERIOD_RST, bpts_pkg::SHORT_MS_RST,
                              bpts_pkg::LONG_MS_RST, bpts_pkg::TICKS_PER_MS_RST};
    bpts_pkg::pattern_t pat_now = bpts_pkg::PAT_OFF;
    bpts_pkg::step_t    step_now = bpts_pkg::STEP_START;
    logic [15:0]        ms_left = '0;
    logic [15:0]        sub_ms = '0;
    logic [15:0]        wave_pos = '0;
    logic [15:0]        period_now = '0;

    bpts_pkg::out_item_t sound_due [$];
    bpts_pkg::out_item_t rx_want;
    int                  err_count = 0;
    int                  cycles = 0;
    int                  rx_hold = 0;
    bit                  no_idle = 1'b0;

    buzzer_pattern_tone_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_reg(int small_max);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'hFFFF;
        if (r == 1)
            return 16'($urandom);
        return 16'($urandom_range(0, small_max));
    endfunction

    function automatic void enter_step(logic [15:0] period, logic [15:0] ms,
                                       bpts_pkg::step_t nxt);
        period_now = period;
        ms_left = ms;
        sub_ms = '0;
        step_now = nxt;
    endfunction

    function automatic void end_pattern();
        period_now = '0;
        pat_now = bpts_pkg::PAT_OFF;
        step_now = bpts_pkg::STEP_START;
        ms_left = '0;
        sub_ms = '0;
    endfunction

    function automatic bpts_pkg::out_item_t sound_of_tick(bpts_pkg::in_item_t it);
        logic [15:0]         prev_period;
        logic [2:0]          req;
        bit                  expired;
        bpts_pkg::out_item_t r;
        prev_period = period_now;
        if (it.cmd)
        begin
            req = it.pattern;
            if (req > bpts_pkg::PAT_ALARM)
                req = bpts_pkg::PAT_OFF;
            if (req != pat_now)
            begin
                pat_now = bpts_pkg::pattern_t'(req);
                step_now = bpts_pkg::STEP_START;
                period_now = '0;
                ms_left = '0;
                sub_ms = '0;
                wave_pos = '0;
            end
        end
        expired = (ms_left == 16'd0);
        case (pat_now)
            bpts_pkg::PAT_DOUBLE:
            begin
                if (step_now == bpts_pkg::STEP_START)
                    enter_step(regs[bpts_pkg::REG_TONE_A_PERIOD],
                               regs[bpts_pkg::REG_SHORT_MS], bpts_pkg::STEP_FIRST);
                else if (expired && step_now == bpts_pkg::STEP_FIRST)
                    enter_step(16'd0, regs[bpts_pkg::REG_SHORT_MS], bpts_pkg::STEP_GAP);
                else if (expired && step_now == bpts_pkg::STEP_GAP)
                    enter_step(regs[bpts_pkg::REG_TONE_A_PERIOD],
                               regs[bpts_pkg::REG_SHORT_MS], bpts_pkg::STEP_LAST);
                else if (expired)
                    end_pattern();
            end
            bpts_pkg::PAT_SINGLE:
            begin
                if (step_now == bpts_pkg::STEP_START)
                    enter_step(regs[bpts_pkg::REG_TONE_A_PERIOD],
                               regs[bpts_pkg::REG_SHORT_MS], bpts_pkg::STEP_FIRST);
                else if (expired)
                    end_pattern();
            end
            bpts_pkg::PAT_BEEP:
            begin
                if (step_now == bpts_pkg::STEP_START)
                    enter_step(regs[bpts_pkg::REG_TONE_B_PERIOD],
                               regs[bpts_pkg::REG_LONG_MS], bpts_pkg::STEP_FIRST);
                else if (expired)
                    end_pattern();
            end
            bpts_pkg::PAT_ALARM:
                period_now = regs[bpts_pkg::REG_ALARM_PERIOD];
            default:
                period_now = '0;
        endcase
        if (ms_left != 16'd0)
        begin
            if (int'(sub_ms) + 1 >= int'(regs[bpts_pkg::REG_TICKS_PER_MS]))
            begin
                sub_ms = '0;
                ms_left = ms_left - 16'd1;
            end
            else
                sub_ms = sub_ms + 16'd1;
        end
        if (period_now != prev_period)
            wave_pos = '0;
        if (period_now == 16'd0)
        begin
            r.tone_out = 1'b0;
            wave_pos = '0;
        end
        else
        begin
            if (wave_pos >= period_now)
                wave_pos = '0;
            r.tone_out = (wave_pos < (period_now >> 1));
            if (int'(wave_pos) + 1 >= int'(period_now))
                wave_pos = '0;
            else
                wave_pos = wave_pos + 16'd1;
        end
        r.active_pattern = pat_now;
        r.busy_res = (pat_now != bpts_pkg::PAT_OFF);
        return r;
    endfunction

    task automatic flag_error(string msg);
        if (err_count < 10)
            $display("%s", msg);
        err_count++;
    endtask

    // hold valid and payload until the tick is taken
    task automatic send_tick(bpts_pkg::in_item_t it, logic use_lit, bpts_pkg::out_item_t lit);
        int                  gap;
        bpts_pkg::out_item_t pred;
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = sound_of_tick(it);
        sound_due.push_back(use_lit ? lit : pred);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sound_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx <= bpts_pkg::REG_TICKS_PER_MS)
            regs[idx] = val;
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (sound_due.size() == 0)
                flag_error($sformatf("unexpected item: tone %0b pat %0d busy %0b",
                                     out_data.tone_out, out_data.active_pattern,
                                     out_data.busy_res));
            else
            begin
                rx_want = sound_due.pop_front();
                if (out_data.tone_out !== rx_want.tone_out
                    || out_data.active_pattern !== rx_want.active_pattern
                    || out_data.busy_res !== rx_want.busy_res)
                    flag_error($sformatf(
                        "mismatch: want tone %0b pat %0d busy %0b, got tone %0b pat %0d busy %0b",
                        rx_want.tone_out, rx_want.active_pattern, rx_want.busy_res,
                        out_data.tone_out, out_data.active_pattern, out_data.busy_res));
            end
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_ready <= 1'b0;
        end
        else
        begin
            rx_hold = idle_len();
            out_ready <= (rx_hold == 0);
        end
    end

    initial
    begin
        bpts_pkg::in_item_t it;
        int                 seq_left;
        longint             tpm;
        longint             dur;
        seq_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].val);
            else
                send_tick(DIR_ROWS[i].tick, DIR_ROWS[i].lit, DIR_ROWS[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_reg(bpts_pkg::REG_TONE_A_PERIOD, rand_reg(12));
            write_reg(bpts_pkg::REG_TONE_B_PERIOD, rand_reg(12));
            write_reg(bpts_pkg::REG_ALARM_PERIOD, rand_reg(12));
            write_reg(bpts_pkg::REG_SHORT_MS, rand_reg(3));
            write_reg(bpts_pkg::REG_LONG_MS, rand_reg(5));
            write_reg(bpts_pkg::REG_TICKS_PER_MS, rand_reg(3));
            no_idle = (ph == 4);
            seq_left = 0;
            for (int k = 0; k < PHASE_TICKS; k++)
            begin
                if (seq_left == 0)
                begin
                    if ($urandom_range(0, 4) != 0)
                    begin
                        it.cmd = 1'b1;
                        it.pattern = 3'($urandom_range(bpts_pkg::PAT_DOUBLE,
                                                       bpts_pkg::PAT_ALARM));
                        tpm = (regs[bpts_pkg::REG_TICKS_PER_MS] == 16'd0)
                              ? 1 : regs[bpts_pkg::REG_TICKS_PER_MS];
                        dur = (3 * (longint'(regs[bpts_pkg::REG_SHORT_MS]) + 1)
                               + longint'(regs[bpts_pkg::REG_LONG_MS]) + 1) * tpm + 4;
                        seq_left = (dur > 90) ? 90 : int'(dur);
                    end
                    else
                    begin
                        it = bpts_pkg::in_item_t'(4'($urandom));
                        seq_left = $urandom_range(0, 3);
                    end
                end
                else
                begin
                    seq_left--;
                    it.cmd = ($urandom_range(0, 29) == 0);
                    it.pattern = 3'($urandom_range(0, 7));
                end
                send_tick(it, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        drain_results();
        if (err_count == 0 && sound_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
